// ===== design/scbpa_pkg.sv =====
// shared types, constants and helpers of the size class block pool allocator
package scbpa_pkg;

    localparam int ADDR_W = 32;
    localparam int IDX_W  = 16;
    localparam int USE_W  = 17;
    localparam int NCLASS = 4;
    localparam int CLS_W  = 2;

    typedef enum logic
    {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_OK        = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NO_POOL   = 3'd3,
        ST_OVER      = 3'd4
    } status_t;

    typedef enum logic
    {
        BK_IDLE,
        BK_READ
    } back_state_t;

    typedef enum logic [1:0]
    {
        REG_BASE0 = 2'd0,
        REG_BASE1 = 2'd1,
        REG_BASE2 = 2'd2,
        REG_BASE3 = 2'd3
    } reg_index_t;

    typedef logic [NCLASS-1:0][ADDR_W-1:0] base_arr_t;

    localparam base_arr_t BASE_RESET = {32'h000C_0000, 32'h0008_0000, 32'h0004_0000, 32'h0};

    localparam logic [ADDR_W-1:0] CLASS_SIZE [NCLASS] = '{32'd64, 32'd256, 32'd1024, 32'd4096};
    localparam int CLASS_SHIFT [NCLASS] = '{6, 8, 10, 12};

    // classified item between front and back
    typedef struct packed
    {
        cmd_t              cmd;
        logic [CLS_W-1:0]  cls;
        status_t           pre;
        logic [ADDR_W-1:0] addr;
    } work_t;

    typedef struct packed
    {
        logic pop;
        logic push;
        logic rd_req;
    } pool_ctl_t;

    typedef struct packed
    {
        logic empty;
        logic full;
        logic fresh;
    } pool_stat_t;

    function automatic logic [ADDR_W-1:0] shl_class(input logic [ADDR_W-1:0] val,
                                                     input logic [CLS_W-1:0] cls);
        logic [ADDR_W-1:0] res;
        case (cls)
            2'd0:    res = val << CLASS_SHIFT[0];
            2'd1:    res = val << CLASS_SHIFT[1];
            2'd2:    res = val << CLASS_SHIFT[2];
            2'd3:    res = val << CLASS_SHIFT[3];
            default: res = val;
        endcase
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] shr_class(input logic [ADDR_W-1:0] val,
                                                     input logic [CLS_W-1:0] cls);
        logic [ADDR_W-1:0] res;
        case (cls)
            2'd0:    res = val >> CLASS_SHIFT[0];
            2'd1:    res = val >> CLASS_SHIFT[1];
            2'd2:    res = val >> CLASS_SHIFT[2];
            2'd3:    res = val >> CLASS_SHIFT[3];
            default: res = val;
        endcase
        return res;
    endfunction

endpackage

// ===== design/scbpa_ram.sv =====
// generic single write port ram with registered read
module scbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/scbpa_front.sv =====
// front end: classifies incoming items and queues them for the back end
module scbpa_front
    import scbpa_pkg::*;
#(
    parameter int unsigned BLOCKS_CLASS0 = 4096,
    parameter int unsigned BLOCKS_CLASS1 = 1024,
    parameter int unsigned BLOCKS_CLASS2 = 256,
    parameter int unsigned BLOCKS_CLASS3 = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  base_arr_t         base,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              in_cmd,
    input  logic [ADDR_W-1:0] in_size,
    input  logic [ADDR_W-1:0] in_addr,
    output logic              q_valid,
    input  logic              q_ready,
    output work_t             q_data
);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int unsigned BLOCKS_ARR [NCLASS] =
        '{BLOCKS_CLASS0, BLOCKS_CLASS1, BLOCKS_CLASS2, BLOCKS_CLASS3};

    work_t            fifo_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   cnt_reg;
    logic [QCW-1:0]   cnt_next;
    logic             push;
    logic             pop;
    work_t            cls_item;
    logic [NCLASS-1:0] hit;
    logic [ADDR_W:0]  hi [NCLASS];

    // range check per region, first hit wins
    always_comb
    begin
        for (int c = 0; c < NCLASS; c++)
        begin
            hi[c]  = {1'b0, base[c]} + ((ADDR_W+1)'(BLOCKS_ARR[c]) << CLASS_SHIFT[c]);
            hit[c] = (in_addr >= base[c]) && ({1'b0, in_addr} < hi[c]);
        end
    end

    always_comb
    begin
        cls_item.cmd  = in_cmd;
        cls_item.addr = in_addr;
        cls_item.cls  = 2'd0;
        cls_item.pre  = ST_OK;
        case (in_cmd)
            CMD_ALLOC:
            begin
                if (in_size <= CLASS_SIZE[0])
                begin
                    cls_item.cls = 2'd0;
                end
                else if (in_size <= CLASS_SIZE[1])
                begin
                    cls_item.cls = 2'd1;
                end
                else if (in_size <= CLASS_SIZE[2])
                begin
                    cls_item.cls = 2'd2;
                end
                else if (in_size <= CLASS_SIZE[3])
                begin
                    cls_item.cls = 2'd3;
                end
                else
                begin
                    cls_item.pre = ST_TOO_LARGE;
                end
            end
            CMD_RELEASE:
            begin
                if (hit[0])
                begin
                    cls_item.cls = 2'd0;
                end
                else if (hit[1])
                begin
                    cls_item.cls = 2'd1;
                end
                else if (hit[2])
                begin
                    cls_item.cls = 2'd2;
                end
                else if (hit[3])
                begin
                    cls_item.cls = 2'd3;
                end
                else
                begin
                    cls_item.pre = ST_NO_POOL;
                end
            end
            default:
            begin
                cls_item.pre = ST_OK;
            end
        endcase
    end

    assign in_ready = (cnt_reg != QCW'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

// ===== design/scbpa_pool.sv =====
// one pool: free index stack in ram, level and low-water mark
module scbpa_pool
    import scbpa_pkg::*;
#(
    parameter int unsigned BLOCKS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pool_ctl_t        ctl,
    input  logic [IDX_W-1:0] push_idx,
    output pool_stat_t       stat,
    output logic [IDX_W-1:0] top_pos,
    output logic [IDX_W-1:0] rd_data,
    output logic [USE_W-1:0] in_use
);

    localparam int LW = $clog2(BLOCKS + 1);
    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [LW-1:0] wm_reg;
    logic [LW-1:0] wm_next;
    logic [LW-1:0] level_dec;
    logic [IW-1:0] ram_rdata;

    assign level_dec = level_reg - 1'b1;

    // entries below the low-water mark were never written; a pop there uses the slot position as its index
    assign stat.empty = (level_reg == '0);
    assign stat.full  = (level_reg == LW'(BLOCKS));
    assign stat.fresh = (level_reg == wm_reg);
    assign top_pos    = IDX_W'(level_dec[IW-1:0]);
    assign rd_data    = IDX_W'(ram_rdata);
    assign in_use     = USE_W'(BLOCKS) - USE_W'(level_reg);

    always_comb
    begin
        level_next = level_reg;
        wm_next    = wm_reg;
        if (ctl.pop)
        begin
            level_next = level_dec;
            if (level_reg == wm_reg)
            begin
                wm_next = level_dec;
            end
        end
        else if (ctl.push)
        begin
            level_next = level_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LW'(BLOCKS);
            wm_reg    <= LW'(BLOCKS);
        end
        else
        begin
            level_reg <= level_next;
            wm_reg    <= wm_next;
        end
    end

    scbpa_ram #(
        .WIDTH(IW),
        .DEPTH(BLOCKS)
    ) u_stack (
        .clk  (clk),
        .we   (ctl.push),
        .waddr(level_reg[IW-1:0]),
        .wdata(push_idx[IW-1:0]),
        .re   (ctl.rd_req),
        .raddr(level_dec[IW-1:0]),
        .rdata(ram_rdata)
    );

    a_wm_le_level: assert property (@(posedge clk) disable iff (!rst_n)
        wm_reg <= level_reg)
        else $error("low-water mark above stack level");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push |-> !stat.full && !ctl.pop)
        else $error("push onto full stack");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> !stat.empty)
        else $error("pop from empty stack");

    a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_req |=> !ctl.push && level_reg == $past(level_reg))
        else $error("stack changed between read and pop");

endmodule

// ===== design/scbpa_back.sv =====
// back end: carries out pops and pushes, keeps counters and the result register
module scbpa_back
    import scbpa_pkg::*;
#(
    parameter int unsigned BLOCKS_CLASS0 = 4096,
    parameter int unsigned BLOCKS_CLASS1 = 1024,
    parameter int unsigned BLOCKS_CLASS2 = 256,
    parameter int unsigned BLOCKS_CLASS3 = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  base_arr_t     base,
    input  logic          q_valid,
    output logic          q_ready,
    input  work_t         q_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [143:0]  out_data,
    output logic [2:0]    out_status
);

    localparam int unsigned BLOCKS_ARR [NCLASS] =
        '{BLOCKS_CLASS0, BLOCKS_CLASS1, BLOCKS_CLASS2, BLOCKS_CLASS3};

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [CLS_W-1:0]  rd_cls_reg;
    logic [CLS_W-1:0]  rd_cls_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [CLS_W-1:0]  cls_reg;
    logic [CLS_W-1:0]  cls_next;
    logic [ADDR_W-1:0] alloc_cnt_reg;
    logic [ADDR_W-1:0] alloc_cnt_next;
    logic [ADDR_W-1:0] rel_cnt_reg;
    logic [ADDR_W-1:0] rel_cnt_next;
    logic              load;
    logic              alloc_inc;
    logic              rel_inc;
    logic              slot_free;
    logic              go_read;
    logic [CLS_W-1:0]  sel;
    logic [ADDR_W-1:0] base_sel;
    logic [IDX_W-1:0]  idx_sel;
    logic [ADDR_W-1:0] alloc_addr;
    logic [ADDR_W-1:0] rel_off;
    logic [IDX_W-1:0]  push_idx;
    pool_ctl_t         ctl [NCLASS];
    pool_stat_t        stat [NCLASS];
    logic [IDX_W-1:0]  top_pos [NCLASS];
    logic [IDX_W-1:0]  rd_data [NCLASS];
    logic [USE_W-1:0]  in_use [NCLASS];

    for (genvar c = 0; c < NCLASS; c++)
    begin : g_pool
        scbpa_pool #(
            .BLOCKS(BLOCKS_ARR[c])
        ) u_pool (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl[c]),
            .push_idx(push_idx),
            .stat    (stat[c]),
            .top_pos (top_pos[c]),
            .rd_data (rd_data[c]),
            .in_use  (in_use[c])
        );
    end

    assign slot_free  = !out_valid_reg || out_ready;
    assign sel        = (state_reg == BK_READ) ? rd_cls_reg : q_data.cls;
    assign base_sel   = base[sel];
    assign idx_sel    = (state_reg == BK_READ) ? rd_data[sel] : top_pos[sel];
    assign alloc_addr = base_sel + shl_class(ADDR_W'(idx_sel), sel);
    assign rel_off    = shr_class(q_data.addr - base_sel, sel);
    assign push_idx   = rel_off[IDX_W-1:0];

    // recycled stack slot: registered ram read before the pop completes
    assign go_read = (state_reg == BK_IDLE) && q_valid && slot_free
                     && (q_data.cmd == CMD_ALLOC) && (q_data.pre == ST_OK)
                     && !stat[sel].empty && !stat[sel].fresh;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (go_read)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready     = 1'b0;
        load        = 1'b0;
        alloc_inc   = 1'b0;
        rel_inc     = 1'b0;
        status_next = ST_OK;
        addr_next   = '0;
        cls_next    = sel;
        rd_cls_next = rd_cls_reg;
        for (int c = 0; c < NCLASS; c++)
        begin
            ctl[c] = '0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_ready = 1'b1;
                    if (q_data.pre != ST_OK)
                    begin
                        load        = 1'b1;
                        status_next = q_data.pre;
                    end
                    else if (q_data.cmd == CMD_ALLOC)
                    begin
                        if (stat[sel].empty)
                        begin
                            load        = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else if (stat[sel].fresh)
                        begin
                            load         = 1'b1;
                            addr_next    = alloc_addr;
                            alloc_inc    = 1'b1;
                            ctl[sel].pop = 1'b1;
                        end
                        else
                        begin
                            ctl[sel].rd_req = 1'b1;
                            rd_cls_next     = sel;
                        end
                    end
                    else
                    begin
                        if (stat[sel].full)
                        begin
                            load        = 1'b1;
                            status_next = ST_OVER;
                        end
                        else
                        begin
                            load          = 1'b1;
                            rel_inc       = 1'b1;
                            ctl[sel].push = 1'b1;
                        end
                    end
                end
            end
            BK_READ:
            begin
                if (slot_free)
                begin
                    load         = 1'b1;
                    addr_next    = alloc_addr;
                    alloc_inc    = 1'b1;
                    ctl[sel].pop = 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !out_ready);
        alloc_cnt_next = alloc_cnt_reg + ADDR_W'(alloc_inc);
        rel_cnt_next   = rel_cnt_reg + ADDR_W'(rel_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            alloc_cnt_reg <= '0;
            rel_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            alloc_cnt_reg <= alloc_cnt_next;
            rel_cnt_reg   <= rel_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cls_reg <= rd_cls_next;
        if (load)
        begin
            status_reg <= status_next;
            addr_reg   <= addr_next;
            cls_reg    <= cls_next;
        end
    end

    // counters and levels only move when no result is held or the held result is taken
    assign out_valid  = out_valid_reg;
    assign out_status = status_reg;
    assign out_data   = {6'b0, in_use[3][6:0], in_use[2][8:0], in_use[1][10:0],
                         in_use[0][12:0], rel_cnt_reg, alloc_cnt_reg, cls_reg, addr_reg};

endmodule

// ===== design/size_class_block_pool_allocator_top.sv =====
// top level of the size class block pool allocator
//
//   group     dir  width  content
//   s_*       in   64+1   tdata: request_size, release_address; tuser: command
//   m_*       out  144+3  tdata: block_address .. in_use_class3; tuser: status
//   cfg_*     in   32     base_class0..3 by index
//
// a release or an alloc from a never-recycled stack slot completes straight from BK_IDLE in the back end
// an alloc that reuses a released slot passes through BK_READ: the stack ram has a registered read
// the front queues up to two classified items, so input is taken while a result waits
// no clearing pass after reset: a low-water mark per pool makes untouched slots read as
// their own index
module size_class_block_pool_allocator_top
    import scbpa_pkg::*;
#(
    parameter int unsigned BLOCKS_CLASS0 = 4096,
    parameter int unsigned BLOCKS_CLASS1 = 1024,
    parameter int unsigned BLOCKS_CLASS2 = 256,
    parameter int unsigned BLOCKS_CLASS3 = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,    // request_size, release_address
    input  logic [0:0]    s_tuser,    // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,    // block_address, size_class, alloc_total,
                                      // release_total, in_use_class0..3, zero pad
    output logic [2:0]    m_tuser,    // status
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    base_arr_t base_reg;
    logic      q_valid;
    logic      q_ready;
    work_t     q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_BASE0: base_reg[0] <= cfg_data;
                REG_BASE1: base_reg[1] <= cfg_data;
                REG_BASE2: base_reg[2] <= cfg_data;
                REG_BASE3: base_reg[3] <= cfg_data;
                default:   base_reg    <= base_reg;
            endcase
        end
    end

    scbpa_front #(
        .BLOCKS_CLASS0(BLOCKS_CLASS0),
        .BLOCKS_CLASS1(BLOCKS_CLASS1),
        .BLOCKS_CLASS2(BLOCKS_CLASS2),
        .BLOCKS_CLASS3(BLOCKS_CLASS3)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .base    (base_reg),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_cmd  (cmd_t'(s_tuser[0])),
        .in_size (s_tdata[31:0]),
        .in_addr (s_tdata[63:32]),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    scbpa_back #(
        .BLOCKS_CLASS0(BLOCKS_CLASS0),
        .BLOCKS_CLASS1(BLOCKS_CLASS1),
        .BLOCKS_CLASS2(BLOCKS_CLASS2),
        .BLOCKS_CLASS3(BLOCKS_CLASS3)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base      (base_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_status(m_tuser)
    );

endmodule
